### sv/ffbp_pkg.sv
// ----------------------------------------------------------------------------
// ffbp_pkg
// Shared types and constants of the first-fit bin packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffbp_pkg;

  localparam int MAX_BINS       = 64;
  localparam int SIZE_FRAC_BITS = 16;
  localparam int SIZE_W         = 17;
  localparam int IDX_W          = $clog2(MAX_BINS);
  localparam int CNT_W          = $clog2(MAX_BINS + 1);
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  // one full unit, saturated to the field width
  localparam logic [SIZE_W-1:0] CAP_RESET =
    ((1 << SIZE_FRAC_BITS) > ((1 << SIZE_W) - 1)) ? {SIZE_W{1'b1}}
                                                  : SIZE_W'(1 << SIZE_FRAC_BITS);

  localparam logic [CNT_W-1:0] BINS_MAX = CNT_W'(MAX_BINS);

  // register index, taken from the word address
  localparam logic REG_BIN_CAPACITY = 1'b0;

  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_OVERSIZE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] item_size;
    logic              start_new_set;
  } in_t;

  typedef struct packed {
    logic [5:0]        bin_index;
    logic              opened_new_bin;
    logic [SIZE_W-1:0] space_left;
    logic [1:0]        status;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic place_hit;
    logic place_new;
    logic err_over;
    logic err_full;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic oversize;
    logic hit;
    logic exhausted;
    logic store_full;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### sv/ffbp_ram.sv
// ----------------------------------------------------------------------------
// ffbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffbp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/ffbp_regs.sv
// ----------------------------------------------------------------------------
// ffbp_regs
// APB register file: holds the bin capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffbp_regs
  import ffbp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [SIZE_W-1:0]     bin_capacity
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity <= CAP_RESET;
    end else if (wr_en && (paddr[2] == REG_BIN_CAPACITY)) begin
      bin_capacity <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BIN_CAPACITY) begin
      prdata = APB_DATA_W'(bin_capacity);
    end
  end

endmodule

`default_nettype wire

### sv/ffbp_ctrl.sv
// ----------------------------------------------------------------------------
// ffbp_ctrl
// Sequencer: accepts an item, steps the bin scan, picks the placement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffbp_ctrl
  import ffbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.oversize || stat.hit || stat.exhausted) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_SCAN: begin
        priority if (stat.oversize) begin
          cmd.err_over = 1'b1;
        end else if (stat.hit) begin
          cmd.place_hit = 1'b1;
        end else if (stat.exhausted) begin
          cmd.err_full  = stat.store_full;
          cmd.place_new = !stat.store_full;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.push = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/ffbp_dp.sv
// ----------------------------------------------------------------------------
// ffbp_dp
// Datapath: bin free-space store, scan counter, compare and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffbp_dp
  import ffbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire in_t               in_data,
  input  wire logic [SIZE_W-1:0] bin_capacity,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_t                   out_data
);

  logic [SIZE_W-1:0] size;
  logic [CNT_W-1:0]  bins_open;
  logic [CNT_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;
  out_t              res;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SIZE_W-1:0] ram_wdata;
  logic [SIZE_W-1:0] ram_rdata;
  logic [SIZE_W-1:0] hit_left;
  logic [SIZE_W-1:0] new_left;
  logic              more;

  ffbp_ram #(
    .WIDTH(SIZE_W),
    .DEPTH(MAX_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign more     = (scan_idx < bins_open);
  assign hit_left = ram_rdata - size;
  assign new_left = bin_capacity - size;

  always_comb begin
    stat.oversize   = (size > bin_capacity);
    stat.hit        = cmp_valid && (size <= ram_rdata);
    stat.exhausted  = !cmp_valid && !more;
    stat.store_full = (bins_open == BINS_MAX);
    stat.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    ram_we    = cmd.place_hit || cmd.place_new;
    ram_waddr = cmd.place_hit ? cmp_idx : bins_open[IDX_W-1:0];
    ram_wdata = cmd.place_hit ? hit_left : new_left;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_open <= '0;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
        if (in_data.start_new_set) begin
          bins_open <= '0;
        end
      end else if (cmd.step) begin
        // read issued now, compared next cycle
        cmp_valid <= more;
        if (more) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (cmd.place_new) begin
        bins_open <= bins_open + 1'b1;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size <= in_data.item_size;
    end
    if (cmd.step) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
    end
    priority if (cmd.place_hit) begin
      res.bin_index      <= 6'(cmp_idx);
      res.opened_new_bin <= 1'b0;
      res.space_left     <= hit_left;
      res.status         <= ST_PLACED;
    end else if (cmd.place_new) begin
      res.bin_index      <= 6'(bins_open[IDX_W-1:0]);
      res.opened_new_bin <= 1'b1;
      res.space_left     <= new_left;
      res.status         <= ST_PLACED;
    end else if (cmd.err_over || cmd.err_full) begin
      res.bin_index      <= '0;
      res.opened_new_bin <= 1'b0;
      res.space_left     <= '0;
      res.status         <= cmd.err_over ? ST_OVERSIZE : ST_FULL;
    end else begin
      res <= res;
    end
    if (cmd.push) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

### sv/first_fit_bin_packer_top.sv
// ----------------------------------------------------------------------------
// first_fit_bin_packer_top
// Online first-fit bin packer: places each item in the lowest open bin
// with enough free space, or opens a new bin.
//
//   channel  signals                          beat
//   in       in_valid, in_stall, in_data      one item (size, start flag)
//   out      out_valid, out_stall, out_data   one placement result
//   cfg      psel, penable, pwrite, paddr,    bin_capacity at word 0
//            pwdata, prdata, pready
//
// After acceptance the open bins are scanned from bin 0 until one fits;
// each bin is compared in the cycle after its registered RAM read. An
// oversize item or an empty store skips the scan. The next item is taken
// once the result has gone to the output register and the sequencer is idle.
// Reset (rst, synchronous) closes all bins and sets the capacity to 1.0.
// A result waits in the output register; the next one waits until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_bin_packer_top
  import ffbp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [SIZE_W-1:0] bin_capacity;
  cmd_t              cmd;
  stat_t             stat;

  ffbp_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .bin_capacity(bin_capacity)
  );

  ffbp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  ffbp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .bin_capacity(bin_capacity),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

### tb/sv/first_fit_bin_packer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_bin_packer_top_tb
// Self-checking bench for the first-fit bin packer. A scoreboard class keeps
// its own copy of the bin store and capacity and predicts the placement of
// every accepted item. Directed sets cover zero, full and oversize items, a
// capacity change inside a set and a full bin store. Random sets of mixed
// or large items run under several capacities, with random gaps on both
// channels and two long output hold-offs.
// ----------------------------------------------------------------------------

module first_fit_bin_packer_top_tb;
  import ffbp_pkg::*;

  localparam int                    IDLE_LIMIT = 4000;
  localparam int                    DRAIN_WAIT = 80;
  localparam int                    HOLD_LEN   = 400;
  localparam int                    PHASE_ITEMS = 305;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR   = APB_ADDR_W'({REG_BIN_CAPACITY, 2'b00});

  class placement_board;
    logic [SIZE_W-1:0] capacity;
    logic [SIZE_W-1:0] bin_room [MAX_BINS];
    int                open_count;
    out_t              placements_q [$];
    int                errors;

    function new();
      capacity   = CAP_RESET;
      open_count = 0;
      errors     = 0;
    endfunction

    function void set_capacity(logic [SIZE_W-1:0] value);
      capacity = value;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s", $time, msg);
      end
    endfunction

    // first-fit placement of one accepted item
    function void note_item(in_t it);
      out_t r;
      bit   found;
      r     = '0;
      found = 1'b0;
      if (it.start_new_set) begin
        open_count = 0;
      end
      if (it.item_size > capacity) begin
        r.status = ST_OVERSIZE;
      end else begin
        for (int j = 0; j < open_count; j++) begin
          if (!found && it.item_size <= bin_room[j]) begin
            bin_room[j] = bin_room[j] - it.item_size;
            r.bin_index   = 6'(j);
            r.space_left  = bin_room[j];
            r.status      = ST_PLACED;
            found         = 1'b1;
          end
        end
        if (!found) begin
          if (open_count >= MAX_BINS) begin
            r.status = ST_FULL;
          end else begin
            bin_room[open_count] = capacity - it.item_size;
            r.bin_index      = 6'(open_count);
            r.opened_new_bin = 1'b1;
            r.space_left     = bin_room[open_count];
            r.status         = ST_PLACED;
            open_count++;
          end
        end
      end
      placements_q = {placements_q, r};
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (placements_q.size() == 0) begin
        report($sformatf("unexpected result beat %p", got));
      end else begin
        exp_r = placements_q.pop_front();
        if (got !== exp_r) begin
          report($sformatf({"result mismatch: bin %0d/%0d new %0d/%0d ",
                            "left %0d/%0d status %0d/%0d (exp/got)"},
                           exp_r.bin_index, got.bin_index,
                           exp_r.opened_new_bin, got.opened_new_bin,
                           exp_r.space_left, got.space_left,
                           exp_r.status, got.status));
        end
      end
    endfunction

    function int outstanding();
      return placements_q.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  placement_board board = new();
  int                    idle_cycles = 0;

  first_fit_bin_packer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // no-progress watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic in_t mk_item(int size, bit start);
    in_t it;
    it.item_size     = SIZE_W'(size);
    it.start_new_set = start;
    return it;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(bit heavy);
    int cap;
    int pick;
    cap  = int'(board.capacity);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1) begin
      return SIZE_W'(cap);
    end
    if (pick == 2 && cap < 65536) begin
      return SIZE_W'($urandom_range(cap + 1, 65536));
    end
    if (heavy) begin
      return SIZE_W'($urandom_range(cap / 2 + 1, cap));
    end
    if (pick < 5) begin
      return SIZE_W'($urandom_range(0, cap / 8));
    end
    return SIZE_W'($urandom_range(0, cap));
  endfunction

  // valid stays high across back-to-back beats
  task automatic offer_item(in_t it, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    board.note_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write, then read back in the following transfer
  task automatic program_capacity(logic [SIZE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.set_capacity(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== APB_DATA_W'(value)) begin
      board.report($sformatf("capacity readback %0d, wrote %0d", prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_sets(int quota);
    int done;
    int len;
    bit heavy;
    bit burst;
    bit fresh;
    bit st;
    done = 0;
    while (done < quota) begin
      heavy = ($urandom_range(0, 3) == 0);
      len   = heavy ? $urandom_range(60, 90) : $urandom_range(1, 40);
      burst = ($urandom_range(0, 3) == 0);
      fresh = ($urandom_range(0, 4) != 0);
      for (int k = 0; k < len; k++) begin
        st = (k == 0) ? fresh : ($urandom_range(0, 39) == 0);
        offer_item(mk_item(int'(pick_size(heavy)), st), burst);
        done++;
      end
    end
  endtask

  // result side: random stall per beat, quiet stretches, two long hold-offs
  initial begin
    int hold;
    int beats;
    bit fast;
    beats = 0;
    fast  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (beats == 150 || beats == 900) begin
        hold = HOLD_LEN;
      end else begin
        hold = fast ? 0 : $urandom_range(0, 19);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      board.check_result(out_data);
      beats++;
      if (beats % 32 == 0) begin
        fast = ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    logic [SIZE_W-1:0] caps [6];
    caps[0] = SIZE_W'(65536);
    caps[1] = SIZE_W'(1);
    caps[2] = SIZE_W'(65535);
    caps[3] = SIZE_W'(3);
    caps[4] = SIZE_W'($urandom_range(2, 65534));
    caps[5] = SIZE_W'(32768);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero size with no bin open, zero size into bin 0, full-size item
    offer_item(mk_item(0, 1'b0), 1'b0);
    offer_item(mk_item(0, 1'b0), 1'b0);
    offer_item(mk_item(65536, 1'b0), 1'b0);
    offer_item(mk_item(65535, 1'b0), 1'b0);
    offer_item(mk_item(1, 1'b0), 1'b0);
    offer_item(mk_item(1, 1'b1), 1'b0);
    offer_item(mk_item(65536, 1'b0), 1'b0);
    drain();

    // smaller capacity mid-set: old bins keep their space, oversize wins first
    program_capacity(SIZE_W'(1000));
    offer_item(mk_item(2000, 1'b0), 1'b0);
    offer_item(mk_item(600, 1'b0), 1'b0);
    offer_item(mk_item(1001, 1'b1), 1'b0);
    offer_item(mk_item(0, 1'b0), 1'b0);

    // fill all bins, then hit the full store
    offer_item(mk_item(1000, 1'b1), 1'b1);
    for (int k = 1; k < MAX_BINS; k++) begin
      offer_item(mk_item(1000, 1'b0), 1'b1);
    end
    offer_item(mk_item(1, 1'b0), 1'b0);
    offer_item(mk_item(0, 1'b0), 1'b0);
    offer_item(mk_item(1000, 1'b0), 1'b0);
    drain();

    foreach (caps[p]) begin
      program_capacity(caps[p]);
      run_random_sets(PHASE_ITEMS);
      drain();
    end

    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
